[rtl/tps_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types and codes for the trial phase sequencer.
// ----------------------------------------------------------------------------
package tps_pkg;

  typedef enum logic [2:0] {
    PH_NONE    = 3'd0,
    PH_PRERUN  = 3'd1,
    PH_PREFB   = 3'd2,
    PH_FB      = 3'd3,
    PH_POSTFB  = 3'd4,
    PH_ITI     = 3'd5,
    PH_POSTRUN = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_PRE_RUN     = 3'd0,
    REG_PRE_FB      = 3'd1,
    REG_FB          = 3'd2,
    REG_POST_FB     = 3'd3,
    REG_INTER_TRIAL = 3'd4,
    REG_TRIALS      = 3'd5,
    REG_MIN_RUN     = 3'd6
  } reg_idx_t;

  // Longest chain: feedback -> post-feedback -> inter-trial -> pre-feedback -> feedback
  localparam int unsigned MaxSteps = 4;

  typedef struct packed {
    logic [15:0] pre_run_blocks;
    logic [15:0] pre_feedback_blocks;
    logic [15:0] feedback_blocks;
    logic [15:0] post_feedback_blocks;
    logic [15:0] inter_trial_blocks;
    logic [15:0] trials_per_run;
    logic [31:0] min_run_blocks;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] blocks_in_phase;
    logic [31:0] blocks_in_run;
    logic [15:0] trial_count;
    logic [7:0]  held_target;
    logic        feedback_flag;
    logic        run_active;
  } seq_state_t;

  typedef struct packed {
    logic trial_began;
    logic feedback_began;
    logic feedback_ended;
    logic trial_ended;
    logic target_taken;
    logic phase_error;
  } events_t;

endpackage
`default_nettype wire

[rtl/trial_phase_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trial_phase_sequencer
// Trial run sequencer: phases advanced by block ticks, start and stop requests.
// ----------------------------------------------------------------------------
// Each request (tick, start or stop) is taken on a valid handshake and its status
// result is ready in the output register the cycle after; one request per
// cycle is sustained while the output is not held, set by the single pass of
// phase logic (at most four phase moves per tick) between the run state and the
// output register. A new request is taken while a result waits, as long as the
// output is free or being taken in the same cycle. Configuration is written
// through APB at byte address 4*index; registers read back their value.
module trial_phase_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // requests
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // cmd[1:0], next_target[9:2]
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // phase[2:0], target_code[10:3], feedback_on[11], running[12],
  // trial_number[28:13], trial_began[29], feedback_began[30],
  // feedback_ended[31], trial_ended[32], target_taken[33], phase_error[34]
  output logic      [39:0] m_axis_tdata
);

  tps_pkg::cfg_t       cfg;
  tps_pkg::seq_state_t st;
  tps_pkg::seq_state_t st_next;
  tps_pkg::events_t    ev;
  tps_pkg::seq_state_t res_st;
  tps_pkg::events_t    res_ev;
  logic                accept;

  tps_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tps_next_state u_next (
    .cfg         (cfg),
    .st          (st),
    .cmd         (tps_pkg::cmd_t'(s_axis_tdata[1:0])),
    .next_target (s_axis_tdata[9:2]),
    .st_next     (st_next),
    .ev          (ev)
  );

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        st <= st_next;
      end
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_st <= st_next;
      res_ev <= ev;
    end
  end

  assign m_axis_tdata = {5'd0,
                         res_ev.phase_error,
                         res_ev.target_taken,
                         res_ev.trial_ended,
                         res_ev.feedback_ended,
                         res_ev.feedback_began,
                         res_ev.trial_began,
                         res_st.trial_count,
                         res_st.run_active,
                         res_st.feedback_flag,
                         res_st.held_target,
                         res_st.phase};

endmodule
`default_nettype wire

[rtl/tps_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tps_cfg_regs
// APB register file holding phase durations and run length settings.
// ----------------------------------------------------------------------------
module tps_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output tps_pkg::cfg_t      cfg
);

  tps_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = tps_pkg::reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        tps_pkg::REG_PRE_RUN:     cfg.pre_run_blocks       <= pwdata[15:0];
        tps_pkg::REG_PRE_FB:      cfg.pre_feedback_blocks  <= pwdata[15:0];
        tps_pkg::REG_FB:          cfg.feedback_blocks      <= pwdata[15:0];
        tps_pkg::REG_POST_FB:     cfg.post_feedback_blocks <= pwdata[15:0];
        tps_pkg::REG_INTER_TRIAL: cfg.inter_trial_blocks   <= pwdata[15:0];
        tps_pkg::REG_TRIALS:      cfg.trials_per_run       <= pwdata[15:0];
        tps_pkg::REG_MIN_RUN:     cfg.min_run_blocks       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tps_pkg::REG_PRE_RUN:     prdata = {16'd0, cfg.pre_run_blocks};
      tps_pkg::REG_PRE_FB:      prdata = {16'd0, cfg.pre_feedback_blocks};
      tps_pkg::REG_FB:          prdata = {16'd0, cfg.feedback_blocks};
      tps_pkg::REG_POST_FB:     prdata = {16'd0, cfg.post_feedback_blocks};
      tps_pkg::REG_INTER_TRIAL: prdata = {16'd0, cfg.inter_trial_blocks};
      tps_pkg::REG_TRIALS:      prdata = {16'd0, cfg.trials_per_run};
      tps_pkg::REG_MIN_RUN:     prdata = cfg.min_run_blocks;
      default:                  prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/tps_next_state.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tps_next_state
// Next run state and event flags for one request.
// ----------------------------------------------------------------------------
module tps_next_state (
  input  wire tps_pkg::cfg_t       cfg,
  input  wire tps_pkg::seq_state_t st,
  input  wire tps_pkg::cmd_t       cmd,
  input  wire logic [7:0]          next_target,
  output tps_pkg::seq_state_t      st_next,
  output tps_pkg::events_t         ev
);

  logic        go;
  logic        moved;
  logic        expired;
  logic        done;
  logic [15:0] dur;

  always_comb begin
    st_next = st;
    ev      = '0;
    go      = 1'b1;
    moved   = 1'b0;
    expired = 1'b0;
    dur     = 16'd0;
    done    = (cfg.trials_per_run != 16'd0) ? (st.trial_count >= cfg.trials_per_run)
                                            : (st.blocks_in_run >= cfg.min_run_blocks);
    case (cmd)
      tps_pkg::CMD_START: begin
        st_next.blocks_in_run   = '0;
        st_next.blocks_in_phase = '0;
        st_next.trial_count     = '0;
        st_next.phase           = tps_pkg::PH_PRERUN;
        st_next.run_active      = 1'b1;
        st_next.held_target     = '0;
        st_next.feedback_flag   = 1'b0;
      end
      tps_pkg::CMD_STOP: begin
        if (st.feedback_flag) begin
          st_next.feedback_flag = 1'b0;
          ev.feedback_ended     = 1'b1;
        end
        if (st.held_target != 8'd0) begin
          st_next.held_target = '0;
          ev.trial_ended      = 1'b1;
        end
        st_next.phase      = tps_pkg::PH_NONE;
        st_next.run_active = 1'b0;
      end
      tps_pkg::CMD_TICK: begin
        if (st.phase == tps_pkg::PH_NONE || st.phase > tps_pkg::PH_POSTRUN) begin
          ev.phase_error = 1'b1;
        end else begin
          for (int i = 0; i < tps_pkg::MaxSteps; i++) begin
            if (go) begin
              case (st_next.phase)
                tps_pkg::PH_PRERUN: dur = cfg.pre_run_blocks;
                tps_pkg::PH_PREFB:  dur = cfg.pre_feedback_blocks;
                tps_pkg::PH_FB:     dur = cfg.feedback_blocks;
                tps_pkg::PH_POSTFB: dur = cfg.post_feedback_blocks;
                tps_pkg::PH_ITI:    dur = cfg.inter_trial_blocks;
                default:            dur = 16'd0;
              endcase
              // after the first move the phase count is zero
              expired = (i == 0) ? (st.blocks_in_phase >= {16'd0, dur}) : (dur == 16'd0);
              if (st_next.phase == tps_pkg::PH_POSTRUN || !expired) begin
                go = 1'b0;
              end else begin
                moved = 1'b1;
                case (st_next.phase)
                  tps_pkg::PH_PRERUN, tps_pkg::PH_ITI: begin
                    st_next.held_target = next_target;
                    ev.target_taken     = 1'b1;
                    ev.trial_began      = 1'b1;
                    if (st_next.trial_count != 16'hFFFF) begin
                      st_next.trial_count = st_next.trial_count + 16'd1;
                    end
                    st_next.phase = tps_pkg::PH_PREFB;
                  end
                  tps_pkg::PH_PREFB: begin
                    st_next.feedback_flag = 1'b1;
                    ev.feedback_began     = 1'b1;
                    st_next.phase         = tps_pkg::PH_FB;
                    go                    = 1'b0;
                  end
                  tps_pkg::PH_FB: begin
                    st_next.feedback_flag = 1'b0;
                    ev.feedback_ended     = 1'b1;
                    st_next.phase         = tps_pkg::PH_POSTFB;
                  end
                  default: begin
                    ev.trial_ended      = 1'b1;
                    st_next.held_target = '0;
                    if (done) begin
                      go                 = 1'b0;
                      st_next.run_active = 1'b0;
                      st_next.phase      = tps_pkg::PH_POSTRUN;
                    end else begin
                      st_next.phase = tps_pkg::PH_ITI;
                    end
                  end
                endcase
              end
            end
          end
          st_next.blocks_in_run = (st.blocks_in_run == 32'hFFFF_FFFF) ?
                                  st.blocks_in_run : st.blocks_in_run + 32'd1;
          if (moved) begin
            st_next.blocks_in_phase = 32'd1;
          end else begin
            st_next.blocks_in_phase = (st.blocks_in_phase == 32'hFFFF_FFFF) ?
                                      st.blocks_in_phase : st.blocks_in_phase + 32'd1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
